// ----- hw/rtl/ssort_pkg.sv -----
// ----------------------------------------------------------------------------
// ssort_pkg
// Shared types for the small stable sorter: controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ssort_pkg;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic insert;   // take the key on the input channel into the store
		logic emit;     // move the lowest held key into the output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic last_beat; // one key left in the store
	} dp_stat_t;

endpackage

// ----- hw/rtl/ssort_dp.sv -----
// ----------------------------------------------------------------------------
// ssort_dp
// Sorted register cells with parallel compare-and-shift insertion, fill
// count, overflow flag, compare mode register and the output register.
// ----------------------------------------------------------------------------
module ssort_dp #(
	parameter int MAX_ITEMS = 32,
	parameter int KEY_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssort_pkg::ctrl_cmd_t cmd,
	output ssort_pkg::dp_stat_t  stat,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data,
	input  logic [31:0]          key_value,
	output logic [31:0]          sorted_value,
	output logic                 last_out,
	output logic                 overflow
);
	import ssort_pkg::*;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	logic [KEY_WIDTH-1:0]    cell_q [MAX_ITEMS];
	logic [KEY_WIDTH-1:0]    cell_d [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]    gt;
	logic [CNT_W-1:0]        fill_q;
	logic                    dropped_q;
	logic                    signed_q;
	logic                    full;
	logic [KEY_WIDTH+31:0]   key_ext;
	logic [KEY_WIDTH-1:0]    key;
	logic [KEY_WIDTH+31:0]   out_ext;
	logic [31:0]             sorted_q;
	logic                    last_q;
	logic                    overflow_q;

	function automatic logic key_gt(input logic [KEY_WIDTH-1:0] a,
		input logic [KEY_WIDTH-1:0] b, input logic sgn);
		logic [KEY_WIDTH-1:0] flip;
		flip = KEY_WIDTH'(sgn) << (KEY_WIDTH - 1);
		return (a ^ flip) > (b ^ flip);
	endfunction

	// zero extend or truncate the 32-bit port to the key width
	assign key_ext = {{KEY_WIDTH{1'b0}}, key_value};
	assign key     = key_ext[KEY_WIDTH-1:0];
	assign full    = (fill_q == CNT_W'(MAX_ITEMS));

	assign cfg_ready = 1'b1;

	genvar i;
	generate
		for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
			assign gt[i] = (CNT_W'(i) < fill_q) && key_gt(cell_q[i], key, signed_q);

			always_comb begin
				cell_d[i] = cell_q[i];
				if (cmd.emit) begin
					// shift down so cell 0 always holds the next key out
					if (i < MAX_ITEMS - 1) begin
						cell_d[i] = cell_q[(i < MAX_ITEMS - 1) ? i + 1 : i];
					end
				end else if (cmd.insert && !full) begin
					if (gt[i] || (fill_q == CNT_W'(i))) begin
						if (i > 0) begin
							cell_d[i] = gt[(i > 0) ? i - 1 : 0] ? cell_q[(i > 0) ? i - 1 : 0] : key;
						end else begin
							cell_d[i] = key;
						end
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_ITEMS; k++) begin
			cell_q[k] <= cell_d[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			dropped_q <= 1'b0;
			signed_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				signed_q <= cfg_data;
			end
			if (cmd.emit) begin
				fill_q <= fill_q - CNT_W'(1);
				if (stat.last_beat) begin
					dropped_q <= 1'b0;
				end
			end else if (cmd.insert) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
		end
	end

	assign out_ext = {32'b0, cell_q[0]};

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sorted_q   <= out_ext[31:0];
			last_q     <= stat.last_beat;
			overflow_q <= dropped_q;
		end
	end

	assign stat.last_beat = (fill_q == CNT_W'(1));
	assign sorted_value   = sorted_q;
	assign last_out       = last_q;
	assign overflow       = overflow_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_ITEMS))
		else $error("fill count beyond capacity");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> fill_q != '0)
		else $error("emit beat from an empty store");

	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && stat.last_beat |=> fill_q == '0 && !dropped_q)
		else $error("store not cleared after final beat");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert && !cmd.emit && !full |=> fill_q == $past(fill_q) + CNT_W'(1))
		else $error("insert did not advance fill count");

endmodule

// ----- hw/rtl/ssort_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssort_ctrl
// Load/emit sequencer: takes keys until the last one of a run, then drains
// the store into the output register one beat at a time.
// ----------------------------------------------------------------------------
module ssort_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 last_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ssort_pkg::ctrl_cmd_t cmd,
	input  ssort_pkg::dp_stat_t  stat
);
	import ssort_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_valid && last_item) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free && stat.last_beat) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.insert = 1'b0;
		cmd.emit   = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready   = 1'b1;
				cmd.insert = in_valid;
			end
			ST_EMIT: begin
				cmd.emit = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/small_stable_sort_top.sv -----
// timing: a key is taken in the cycle it is offered while loading; the first
// result is valid once the emit state has loaded the output register
// throughput: one key per cycle while loading, then one result beat per cycle
// while draining n held keys with out_ready high; no key is taken in the drain
// reset: arst_n clears state, fill count, overflow flag and compare mode;
// the key cells are not cleared
// ----------------------------------------------------------------------------
// small_stable_sort_top
// Stable insertion sorter for short runs of keys with overflow marking and
// a signed or unsigned compare mode.
// ----------------------------------------------------------------------------
module small_stable_sort_top #(
	parameter int MAX_ITEMS = 32,
	parameter int KEY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] key_value,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sorted_value,
	output logic        last_out,
	output logic        overflow
);
	import ssort_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	ssort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last_item (last_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	ssort_dp #(
		.MAX_ITEMS (MAX_ITEMS),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.key_value    (key_value),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.overflow     (overflow)
	);

endmodule
